FILE: rtl/indexed_list_insert_delete_get_unit_macros.svh
// assertion macros for the indexed list unit and its checker
`ifndef INDEXED_LIST_INSERT_DELETE_GET_UNIT_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_GET_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define ILIDG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define ILIDG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ilidg_pkg.sv
package ilidg_pkg;

	localparam int unsigned MODE_BITS   = 3;
	localparam int unsigned INDEX_BITS  = 8;
	localparam int unsigned WORD_BITS   = 32;
	localparam int unsigned LENGTH_BITS = 7;

	// operation codes; the remaining codes do nothing
	typedef enum logic [MODE_BITS-1:0] {
		MODE_READ       = 3'd0,
		MODE_INS_FRONT  = 3'd1,
		MODE_APPEND     = 3'd2,
		MODE_INS_BEFORE = 3'd3,
		MODE_DELETE     = 3'd4
	} mode_t;

	typedef struct packed {
		logic [MODE_BITS-1:0]         mode;
		logic [INDEX_BITS-1:0]        index;
		logic signed [WORD_BITS-1:0]  value;
	} in_word_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0]  read_value;
		logic                         ok;
		logic [LENGTH_BITS-1:0]       length;
	} out_word_t;

	// shift command broadcast along the row of cells
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage

FILE: rtl/ilidg_cell.sv
module ilidg_cell import ilidg_pkg::*; #(
	parameter int unsigned POS        = 0,
	parameter int unsigned POS_BITS   = 8,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                         clk,
	input  cell_ctl_t                    ctl,
	input  logic [POS_BITS-1:0]          pos,
	input  logic [POS_BITS-1:0]          rd_pos,
	input  logic signed [VALUE_BITS-1:0] wr_val,
	input  logic signed [VALUE_BITS-1:0] left_val,
	input  logic signed [VALUE_BITS-1:0] right_val,
	output logic signed [VALUE_BITS-1:0] val,
	output logic signed [VALUE_BITS-1:0] rd_val
);

	localparam logic [POS_BITS-1:0] MY_POS = POS_BITS'(POS);

	logic signed [VALUE_BITS-1:0] val_q;

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (MY_POS == pos) begin
				val_q <= wr_val;
			end else if (MY_POS > pos) begin
				val_q <= left_val;
			end
		end else if (ctl.del) begin
			if (MY_POS >= pos) begin
				val_q <= right_val;
			end
		end
	end

	assign val    = val_q;
	assign rd_val = (rd_pos == MY_POS) ? val_q : '0;

endmodule

FILE: rtl/indexed_list_insert_delete_get_unit.sv
// channel   | dir | handshake                 | word
// ----------+-----+---------------------------+-----------------------------
// command   | in  | start high while busy low | cmd    : in_word_t
// result    | out | done, one cycle only      | result : out_word_t
//
// one command per cycle; its result shows in the cycle after acceptance
// the affected cells of the row shift in the acceptance cycle, so busy stays low
// arst_n clears the element count and the result strobe; cell contents are
// left as they are, and only cells below the count are ever read
// the receiver cannot stall: done flags every result for one cycle only
module indexed_list_insert_delete_get_unit import ilidg_pkg::*; #(
	parameter int unsigned CAPACITY   = 64,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_word_t  cmd,
	output logic      done,
	output out_word_t result
);

	// count must hold CAPACITY itself
	localparam int unsigned CNT_BITS = $clog2(CAPACITY + 1);
	// compare width wide enough for both the index field and the count
	localparam int unsigned POS_BITS = (CNT_BITS > INDEX_BITS) ? CNT_BITS : INDEX_BITS;

	logic [CNT_BITS-1:0] count_q;
	logic [CNT_BITS-1:0] count_nxt;
	logic                done_q;
	out_word_t           result_q;

	logic                accept;
	logic [POS_BITS-1:0] idx_w;
	logic [POS_BITS-1:0] cnt_w;
	logic [POS_BITS-1:0] ins_pos;
	logic                full;
	logic                idx_in_range;
	logic                ins_ok;
	logic                ok;
	logic signed [WORD_BITS-1:0] rd_word;
	cell_ctl_t           ctl;

	logic signed [VALUE_BITS-1:0] wr_val;
	logic signed [VALUE_BITS-1:0] cell_val [CAPACITY];
	logic signed [VALUE_BITS-1:0] cell_rd  [CAPACITY];
	logic signed [VALUE_BITS-1:0] rd_or;

	// every command is taken the cycle it arrives
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign idx_w        = POS_BITS'(cmd.index);
	assign cnt_w        = POS_BITS'(count_q);
	assign full         = (count_q == CNT_BITS'(CAPACITY));
	assign idx_in_range = (idx_w < cnt_w);
	// stored width follows VALUE_BITS, sign-extended or truncated
	assign wr_val       = VALUE_BITS'(cmd.value);

	// insert position per mode and the decode of the command
	always_comb begin
		ins_pos   = '0;
		ins_ok    = 1'b0;
		ctl       = '0;
		ok        = 1'b0;
		rd_word   = '0;
		count_nxt = count_q;
		unique case (cmd.mode)
			MODE_READ: begin
				ok      = idx_in_range;
				// narrow store widths come back sign-extended
				rd_word = idx_in_range ? WORD_BITS'(rd_or) : -32'sd1;
			end
			MODE_INS_FRONT, MODE_APPEND, MODE_INS_BEFORE: begin
				if (cmd.mode == MODE_INS_FRONT) begin
					ins_pos = '0;
				end else if (cmd.mode == MODE_APPEND) begin
					ins_pos = cnt_w;
				end else begin
					ins_pos = idx_w;
				end
			end
			MODE_DELETE: begin
				ok = idx_in_range;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		if (cmd.mode == MODE_INS_FRONT || cmd.mode == MODE_APPEND ||
				cmd.mode == MODE_INS_BEFORE) begin
			// rejected when full or when the slot lies past the end
			ins_ok = !full && (ins_pos <= cnt_w);
			ok = ins_ok;
			ctl.ins = accept && ins_ok;
			if (ins_ok) begin
				count_nxt = count_q + CNT_BITS'(1);
			end
		end
		if (cmd.mode == MODE_DELETE) begin
			ctl.del = accept && idx_in_range;
			if (idx_in_range) begin
				count_nxt = count_q - CNT_BITS'(1);
			end
		end
	end

	// the row of cells; each takes from its neighbour when the row shifts
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_BITS-1:0] left_v;
		logic signed [VALUE_BITS-1:0] right_v;
		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = cell_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = cell_val[i+1];
		end
		ilidg_cell #(
			.POS        (i),
			.POS_BITS   (POS_BITS),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.pos       (ctl.del ? idx_w : ins_pos),
			.rd_pos    (idx_w),
			.wr_val    (wr_val),
			.left_val  (left_v),
			.right_val (right_v),
			.val       (cell_val[i]),
			.rd_val    (cell_rd[i])
		);
	end

	// only the addressed cell drives a non-zero word, so an or gathers it
	always_comb begin
		rd_or = '0;
		for (int unsigned i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_nxt;
			end
		end
	end

	// result word, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.read_value <= rd_word;
			result_q.ok         <= ok;
			result_q.length     <= LENGTH_BITS'(count_nxt);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: rtl/ilidg_checker.sv
`include "indexed_list_insert_delete_get_unit_macros.svh"

module ilidg_checker import ilidg_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input in_word_t  cmd,
	input logic      done,
	input out_word_t result
);

	// every accepted word gives a result on the next cycle
	`ILIDG_ASSERT_NEXT(a_result_follows, start && !busy, done, "accepted word gave no result")

	// no result without an accepted word the cycle before
	`ILIDG_ASSERT_NOW(a_no_stray_result, done, $past(start && !busy), "result without a command")

	// a rejected operation leaves the length untouched
	`ILIDG_ASSERT_NOW(a_reject_keeps_len, done && $past(done) && !result.ok, result.length == $past(result.length), "rejected operation changed the length")

	// reads never change the length
	`ILIDG_ASSERT_NOW(a_read_keeps_len, done && $past(done) && $past(cmd.mode == MODE_READ), result.length == $past(result.length), "read changed the length")

endmodule

bind indexed_list_insert_delete_get_unit ilidg_checker u_ilidg_checker (.*);

FILE: tb/tb_top.sv
module tb_top;
	import ilidg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAPACITY     = 64;
	localparam int unsigned VALUE_BITS   = 32;
	localparam int unsigned CLK_PERIOD   = 12;
	localparam int unsigned RESET_CYCLES = 9;
	localparam int unsigned PHASE_ITEMS  = 510;
	localparam int unsigned BIAS_STRETCH = 120;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT  = 100000;
	localparam int unsigned REPORT_MAX   = 10;
	localparam int unsigned DIRECTED_LEN = 24;

	// codes outside the operation set, which must leave the list alone
	localparam logic [MODE_BITS-1:0] MODE_SPARE_A = 3'd5;
	localparam logic [MODE_BITS-1:0] MODE_SPARE_B = 3'd6;
	localparam logic [MODE_BITS-1:0] MODE_SPARE_C = 3'd7;

	localparam logic [WORD_BITS-1:0] NO_ELEMENT = 32'hFFFF_FFFF;
	localparam logic [WORD_BITS-1:0] ALL_ONES   = 32'hFFFF_FFFF;
	localparam logic [WORD_BITS-1:0] VAL_MIN    = 32'h8000_0000;
	localparam logic [WORD_BITS-1:0] VAL_MAX    = 32'h7FFF_FFFF;
	localparam logic [WORD_BITS-1:0] VAL_ALT_A  = 32'h5555_5555;
	localparam logic [WORD_BITS-1:0] VAL_ALT_B  = 32'hAAAA_AAAA;

	// stimulus mix, changed every stretch of random words
	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} op_mix_t;

	typedef struct packed {
		logic [MODE_BITS-1:0]  mode;
		logic [INDEX_BITS-1:0] index;
		logic [WORD_BITS-1:0]  value;
		logic                  typed;
		out_word_t             want;
	} directed_row_t;

	// opening words: empty list corners, spare codes, every insert flavour,
	// reads at the ends, out-of-range inserts and deletes
	localparam directed_row_t DIRECTED_OPS [DIRECTED_LEN] = '{
		'{MODE_READ,       8'd0,   32'd0,     1'b1, '{NO_ELEMENT, 1'b0, 7'd0}},
		'{MODE_READ,       8'd255, 32'd0,     1'b1, '{NO_ELEMENT, 1'b0, 7'd0}},
		'{MODE_DELETE,     8'd0,   32'd0,     1'b1, '{32'd0,      1'b0, 7'd0}},
		'{MODE_INS_BEFORE, 8'd1,   VAL_MAX,   1'b1, '{32'd0,      1'b0, 7'd0}},
		'{MODE_SPARE_A,    8'd0,   VAL_MIN,   1'b1, '{32'd0,      1'b0, 7'd0}},
		'{MODE_SPARE_B,    8'd255, ALL_ONES,  1'b1, '{32'd0,      1'b0, 7'd0}},
		'{MODE_SPARE_C,    8'd128, VAL_ALT_A, 1'b1, '{32'd0,      1'b0, 7'd0}},
		'{MODE_INS_BEFORE, 8'd0,   VAL_MIN,   1'b1, '{32'd0,      1'b1, 7'd1}},
		'{MODE_APPEND,     8'd255, VAL_MAX,   1'b1, '{32'd0,      1'b1, 7'd2}},
		'{MODE_INS_FRONT,  8'd127, ALL_ONES,  1'b1, '{32'd0,      1'b1, 7'd3}},
		'{MODE_INS_BEFORE, 8'd3,   32'd0,     1'b1, '{32'd0,      1'b1, 7'd4}},
		'{MODE_INS_BEFORE, 8'd2,   VAL_ALT_A, 1'b1, '{32'd0,      1'b1, 7'd5}},
		'{MODE_READ,       8'd0,   VAL_ALT_B, 1'b1, '{ALL_ONES,   1'b1, 7'd5}},
		'{MODE_READ,       8'd1,   32'd0,     1'b0, '{32'd0,      1'b0, 7'd0}},
		'{MODE_READ,       8'd3,   32'd0,     1'b0, '{32'd0,      1'b0, 7'd0}},
		'{MODE_READ,       8'd4,   32'd0,     1'b0, '{32'd0,      1'b0, 7'd0}},
		'{MODE_READ,       8'd5,   32'd0,     1'b1, '{NO_ELEMENT, 1'b0, 7'd5}},
		'{MODE_INS_BEFORE, 8'd7,   VAL_ALT_B, 1'b1, '{32'd0,      1'b0, 7'd5}},
		'{MODE_DELETE,     8'd5,   32'd0,     1'b1, '{32'd0,      1'b0, 7'd5}},
		'{MODE_DELETE,     8'd0,   32'd0,     1'b1, '{32'd0,      1'b1, 7'd4}},
		'{MODE_DELETE,     8'd3,   32'd0,     1'b0, '{32'd0,      1'b0, 7'd0}},
		'{MODE_READ,       8'd2,   32'd0,     1'b0, '{32'd0,      1'b0, 7'd0}},
		'{MODE_APPEND,     8'd0,   VAL_ALT_B, 1'b0, '{32'd0,      1'b0, 7'd0}},
		'{MODE_READ,       8'd3,   32'd0,     1'b0, '{32'd0,      1'b0, 7'd0}}
	};

	logic      clk = 1'b0;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_word_t  cmd;
	logic      done;
	out_word_t result;

	// shadow of the list, owned by the sending process alone
	logic signed [WORD_BITS-1:0] held_values [CAPACITY];
	int unsigned                 held_count;

	out_word_t   pending_results [$];
	int unsigned fault_count;
	int unsigned reported_count;
	int unsigned cycle_count;

	indexed_list_insert_delete_get_unit #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// applies one word to the shadow list and returns the result it yields
	function automatic out_word_t apply_list_op(input in_word_t w);
		out_word_t   r;
		int unsigned pos;
		logic        grows;
		r     = '0;
		pos   = 0;
		grows = 1'b0;
		case (w.mode)
			MODE_READ: begin
				if (w.index < held_count) begin
					r.read_value = held_values[w.index];
					r.ok         = 1'b1;
				end else begin
					r.read_value = NO_ELEMENT;
				end
			end
			MODE_INS_FRONT: begin
				grows = 1'b1;
				pos   = 0;
			end
			MODE_APPEND: begin
				grows = 1'b1;
				pos   = held_count;
			end
			MODE_INS_BEFORE: begin
				grows = 1'b1;
				pos   = w.index;
			end
			MODE_DELETE: begin
				if (w.index < held_count) begin
					// close the gap: later elements move one place down
					for (int unsigned i = w.index; i + 1 < held_count; i++)
						held_values[i] = held_values[i + 1];
					held_count--;
					r.ok = 1'b1;
				end
			end
			default: ;
		endcase
		// a full list or a position past the end rejects the insert
		if (grows && held_count < CAPACITY && pos <= held_count) begin
			for (int unsigned i = held_count; i > pos; i--)
				held_values[i] = held_values[i - 1];
			held_values[pos] = w.value;
			held_count++;
			r.ok = 1'b1;
		end
		r.length = LENGTH_BITS'(held_count);
		return r;
	endfunction

	// one word on the command channel, optionally after some idle cycles;
	// the expectation is queued at the edge that accepts the word
	task automatic issue_word(input in_word_t w, input logic typed, input out_word_t want,
			input int unsigned idle_pct);
		out_word_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = apply_list_op(w);
		pending_results.push_back(typed ? want : predicted);
	endtask

	function automatic logic [WORD_BITS-1:0] pick_value();
		if ($urandom_range(9) != 0)
			return $urandom();
		case ($urandom_range(4))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return ALL_ONES;
			3: return 32'd1;
			default: return 32'd0;
		endcase
	endfunction

	// random word steered by the current mix; positions mostly land inside
	// the list or on its end, the rest anywhere in the index range
	function automatic in_word_t pick_word(input op_mix_t mix);
		in_word_t    w;
		int unsigned roll;
		int unsigned ins_pct;
		int unsigned del_pct;
		case (mix)
			MIX_FILL: begin
				ins_pct = 75;
				del_pct = 7;
			end
			MIX_DRAIN: begin
				ins_pct = 17;
				del_pct = 60;
			end
			default: begin
				ins_pct = 47;
				del_pct = 25;
			end
		endcase
		roll = $urandom_range(99);
		if (roll < 3) begin
			case ($urandom_range(2))
				0: w.mode = MODE_SPARE_A;
				1: w.mode = MODE_SPARE_B;
				default: w.mode = MODE_SPARE_C;
			endcase
		end else if (roll < 3 + ins_pct) begin
			case ($urandom_range(2))
				0: w.mode = MODE_INS_FRONT;
				1: w.mode = MODE_APPEND;
				default: w.mode = MODE_INS_BEFORE;
			endcase
		end else if (roll < 3 + ins_pct + del_pct) begin
			w.mode = MODE_DELETE;
		end else begin
			w.mode = MODE_READ;
		end
		roll = $urandom_range(99);
		if (roll < 15)
			w.index = INDEX_BITS'($urandom_range(255));
		else if (roll < 22)
			w.index = INDEX_BITS'(held_count);
		else if (held_count == 0)
			w.index = '0;
		else
			w.index = INDEX_BITS'($urandom_range(held_count - 1));
		w.value = pick_value();
		return w;
	endfunction

	// result side: every strobe is matched against the oldest expectation
	task automatic check_result(input out_word_t got);
		out_word_t want;
		if (pending_results.size() == 0) begin
			fault_count++;
			if (reported_count < REPORT_MAX) begin
				reported_count++;
				$display("unexpected result word: read_value=%0d ok=%0b length=%0d",
					got.read_value, got.ok, got.length);
			end
		end else begin
			want = pending_results.pop_front();
			if (got.read_value !== want.read_value || got.ok !== want.ok ||
					got.length !== want.length) begin
				fault_count++;
				if (reported_count < REPORT_MAX) begin
					reported_count++;
					$display("result mismatch: want read_value=%0d ok=%0b length=%0d, got read_value=%0d ok=%0b length=%0d",
						want.read_value, want.ok, want.length,
						got.read_value, got.ok, got.length);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done)
			check_result(result);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		in_word_t    w;
		out_word_t   no_want;
		op_mix_t     mix;
		int unsigned idle_pct;
		int unsigned settle;
		arst_n         = 1'b0;
		start          = 1'b0;
		cmd            = '0;
		held_count     = 0;
		fault_count    = 0;
		reported_count = 0;
		cycle_count    = 0;
		no_want        = '0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words first
		for (int unsigned n = 0; n < DIRECTED_LEN; n++) begin
			w.mode  = DIRECTED_OPS[n].mode;
			w.index = DIRECTED_OPS[n].index;
			w.value = DIRECTED_OPS[n].value;
			issue_word(w, DIRECTED_OPS[n].typed, DIRECTED_OPS[n].want, 33);
		end

		// random words in three idling phases: light, heavy, none;
		// before each phase the sender holds off until the list side is quiet
		for (int unsigned phase = 0; phase < 3; phase++) begin
			case (phase)
				0: idle_pct = 33;
				1: idle_pct = 65;
				default: idle_pct = 0;
			endcase
			start <= 1'b0;
			@(posedge clk);
			while (pending_results.size() != 0)
				@(posedge clk);
			for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
				// fill, drain and even stretches so the list hits full and empty
				case ((n / BIAS_STRETCH) % 3)
					0: mix = MIX_FILL;
					1: mix = MIX_DRAIN;
					default: mix = MIX_EVEN;
				endcase
				w = pick_word(mix);
				issue_word(w, 1'b0, no_want, idle_pct);
			end
		end
		start <= 1'b0;

		// drain the last results, then a few quiet cycles for stray strobes
		while (pending_results.size() != 0)
			@(posedge clk);
		for (settle = 0; settle < DRAIN_CYCLES; settle++)
			@(posedge clk);
		if (pending_results.size() != 0)
			fault_count++;

		if (fault_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ilidg_pkg.sv
rtl/ilidg_cell.sv
rtl/indexed_list_insert_delete_get_unit.sv
rtl/ilidg_checker.sv
tb/tb_top.sv
